FILE: rtl/dsw_pkg.sv
// Shared types, constants and the digit pattern table of the stopwatch block.
// No dependencies; every other file but dsw_checker imports this package.
`default_nettype none

package dsw_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LIMIT   = 8'd1;

  localparam logic [7:0]  DEBOUNCE_LIMIT_RST = 8'd8;
  localparam logic [15:0] SECOND_LIMIT_RST   = 16'd488;

  // Last value of a units digit and of a tens digit before it wraps
  localparam logic [3:0] ONES_TOP = 4'd9;
  localparam logic [2:0] TENS_TOP = 3'd5;

  // Segment patterns, bit0 = a .. bit6 = g; codes above nine are blank
  localparam logic [6:0] SEG_TABLE [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef struct packed {
    logic [7:0]  debounce_limit;
    logic [15:0] second_limit;
  } dsw_cfg_t;

  typedef struct packed {
    logic [2:0] min_tens;
    logic [3:0] min_ones;
    logic [2:0] sec_tens;
    logic [3:0] sec_ones;
  } dsw_digits_t;

  typedef struct packed {
    logic [6:0]  segments;
    logic [3:0]  digit_enable;
    logic        running;
    dsw_digits_t digits;
  } dsw_result_t;

endpackage

`default_nettype wire

FILE: rtl/dsw_if.sv
// Handshake channel interfaces: poll input, result output, config write.
// Uses dsw_pkg for the config field widths.
`default_nettype none

interface dsw_in_if;
  logic valid;
  logic ready;
  logic timer_tick;
  logic button_level;

  modport source (output valid, output timer_tick, output button_level, input ready);
  modport sink   (input valid, input timer_tick, input button_level, output ready);
endinterface

interface dsw_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] segments;
  logic [3:0] digit_enable;
  logic       running;
  logic [3:0] sec_ones;
  logic [2:0] sec_tens;
  logic [3:0] min_ones;
  logic [2:0] min_tens;

  modport source (output valid, output segments, output digit_enable, output running,
                  output sec_ones, output sec_tens, output min_ones, output min_tens,
                  input ready);
  modport sink   (input valid, input segments, input digit_enable, input running,
                  input sec_ones, input sec_tens, input min_ones, input min_tens,
                  output ready);
endinterface

interface dsw_cfg_if
  import dsw_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/dsw_ctrl.sv
// Debounce, run/pause toggle, sub-second counter and MM:SS digit counter.
// Depends on dsw_pkg. Next values are exported for the scan and result logic.
`default_nettype none

module dsw_ctrl
  import dsw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic        timer_tick,
  input  wire logic        button_level,
  input  wire dsw_cfg_t    cfg,
  output      logic        run_nxt,
  output      dsw_digits_t digits_nxt
);

  logic [7:0]  deb_cnt_r, deb_cnt_nxt, deb_ticked;
  logic        prev_level_r;
  logic        run_r;
  logic [15:0] sub_cnt_r, sub_cnt_nxt, sub_ticked;
  dsw_digits_t digits_r;
  logic        press;
  logic        sec_wrap;

  // The accepted level always settles back to released within the same
  // poll, so only the press event itself needs to be derived.
  always_comb begin
    deb_ticked = (timer_tick && deb_cnt_r != 8'd0) ? deb_cnt_r + 8'd1 : deb_cnt_r;
    sub_ticked = (timer_tick && run_r) ? sub_cnt_r + 16'd1 : sub_cnt_r;
    press      = 1'b0;
    if (button_level != prev_level_r) begin
      deb_cnt_nxt = 8'd1;
    end else if (deb_ticked > cfg.debounce_limit) begin
      deb_cnt_nxt = 8'd0;
      press       = !button_level;
    end else begin
      deb_cnt_nxt = deb_ticked;
    end
    run_nxt     = run_r ^ press;
    sec_wrap    = sub_ticked > cfg.second_limit;
    sub_cnt_nxt = sec_wrap ? 16'd0 : sub_ticked;

    // Ripple carry through the four digits
    digits_nxt = digits_r;
    if (sec_wrap) begin
      if (digits_r.sec_ones != ONES_TOP) begin
        digits_nxt.sec_ones = digits_r.sec_ones + 4'd1;
      end else begin
        digits_nxt.sec_ones = 4'd0;
        if (digits_r.sec_tens != TENS_TOP) begin
          digits_nxt.sec_tens = digits_r.sec_tens + 3'd1;
        end else begin
          digits_nxt.sec_tens = 3'd0;
          if (digits_r.min_ones != ONES_TOP) begin
            digits_nxt.min_ones = digits_r.min_ones + 4'd1;
          end else begin
            digits_nxt.min_ones = 4'd0;
            if (digits_r.min_tens != TENS_TOP) begin
              digits_nxt.min_tens = digits_r.min_tens + 3'd1;
            end else begin
              digits_nxt.min_tens = 3'd0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_cnt_r    <= 8'd0;
      prev_level_r <= 1'b0;
      run_r        <= 1'b0;
      sub_cnt_r    <= 16'd0;
      digits_r     <= '0;
    end else if (accept) begin
      deb_cnt_r    <= deb_cnt_nxt;
      prev_level_r <= button_level;
      run_r        <= run_nxt;
      sub_cnt_r    <= sub_cnt_nxt;
      digits_r     <= digits_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dsw_scan.sv
// Display scan: phase counter and the latched segment pattern and enable.
// Depends on dsw_pkg for the digit struct and the segment table.
`default_nettype none

module dsw_scan
  import dsw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic        timer_tick,
  input  wire dsw_digits_t digits_nxt,
  output      logic [6:0]  seg_nxt,
  output      logic [3:0]  enable_nxt
);

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] last_phase_r;
  logic [6:0] seg_r;
  logic [3:0] enable_r;
  logic [3:0] digit_sel;

  always_comb begin
    phase_nxt = timer_tick ? phase_r + 2'd1 : phase_r;
    unique case (phase_nxt)
      2'd0:    digit_sel = digits_nxt.sec_ones;
      2'd1:    digit_sel = {1'b0, digits_nxt.sec_tens};
      2'd2:    digit_sel = digits_nxt.min_ones;
      default: digit_sel = {1'b0, digits_nxt.min_tens};
    endcase
    if (phase_nxt != last_phase_r) begin
      seg_nxt    = SEG_TABLE[digit_sel];
      enable_nxt = 4'b0001 << phase_nxt;
    end else begin
      seg_nxt    = seg_r;
      enable_nxt = enable_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 2'd0;
      last_phase_r <= 2'd0;
      seg_r        <= 7'd0;
      enable_r     <= 4'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      last_phase_r <= phase_nxt;
      seg_r        <= seg_nxt;
      enable_r     <= enable_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dsw_skid.sv
// Result register with one skid entry, so input can be taken while a
// result waits. Depends on dsw_pkg for the result struct.
`default_nettype none

module dsw_skid
  import dsw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire dsw_result_t push_data,
  output      logic        push_ready,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      dsw_result_t out_data
);

  logic        out_valid_r, skid_valid_r;
  dsw_result_t out_data_r, skid_data_r;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/debounced_stopwatch_mmss_display_unit.sv
// Top level of the MM:SS stopwatch with debounced run/pause and display scan.
// Depends on dsw_pkg, the dsw_*_if interfaces, dsw_ctrl, dsw_scan, dsw_skid.
//
// Usage:
//   in_bus  : one beat per poll, carrying timer_tick (prescaled timer overflow)
//             and button_level (raw, 0 = pressed).
//   out_bus : one result beat per input beat, carrying the latched segment
//             pattern and digit enable, the run flag and the four time digits,
//             all as they stand after that poll.
//   cfg_bus : register writes, always ready; index 0 = debounce_limit,
//             index 1 = second_limit, other indexes are ignored. Write only
//             while no result is outstanding.
// Timing: all state updates happen in the cycle a poll beat is taken; its
//   result is on out_bus from the next cycle if free. Rate is one poll per
//   cycle while ready; an update is one pass of small counters and compares.
// Stall: a result waiting on out_bus does not block input; one more poll is
//   taken into the skid entry, after which in_bus.ready drops until out_bus
//   drains.
// Reset (rst_n low, synchronous): paused, time 00:00, counters cleared,
//   display latches blank, limits back to 8 and 488, no result pending.
`default_nettype none

module debounced_stopwatch_mmss_display_unit
  import dsw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  dsw_in_if.sink    in_bus,
  dsw_out_if.source out_bus,
  dsw_cfg_if.sink   cfg_bus
);

  dsw_cfg_t    cfg_r;
  logic        accept;
  logic        push_ready;
  logic        run_nxt;
  dsw_digits_t digits_nxt;
  logic [6:0]  seg_nxt;
  logic [3:0]  enable_nxt;
  dsw_result_t result;
  dsw_result_t out_data;

  // Config registers: writes complete in the cycle they are offered
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit <= DEBOUNCE_LIMIT_RST;
      cfg_r.second_limit   <= SECOND_LIMIT_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_DEBOUNCE_LIMIT: cfg_r.debounce_limit <= cfg_bus.data[7:0];
        REG_SECOND_LIMIT:   cfg_r.second_limit   <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // A poll is taken whenever the skid entry is free
  assign in_bus.ready = push_ready;
  assign accept       = in_bus.valid && push_ready;

  dsw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .timer_tick   (in_bus.timer_tick),
    .button_level (in_bus.button_level),
    .cfg          (cfg_r),
    .run_nxt      (run_nxt),
    .digits_nxt   (digits_nxt)
  );

  // Scan latches see the digits after this poll's carry
  dsw_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .timer_tick (in_bus.timer_tick),
    .digits_nxt (digits_nxt),
    .seg_nxt    (seg_nxt),
    .enable_nxt (enable_nxt)
  );

  always_comb begin
    result.segments     = seg_nxt;
    result.digit_enable = enable_nxt;
    result.running      = run_nxt;
    result.digits       = digits_nxt;
  end

  dsw_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (result),
    .push_ready (push_ready),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_data   (out_data)
  );

  assign out_bus.segments     = out_data.segments;
  assign out_bus.digit_enable = out_data.digit_enable;
  assign out_bus.running      = out_data.running;
  assign out_bus.sec_ones     = out_data.digits.sec_ones;
  assign out_bus.sec_tens     = out_data.digits.sec_tens;
  assign out_bus.min_ones     = out_data.digits.min_ones;
  assign out_bus.min_tens     = out_data.digits.min_tens;

endmodule

`default_nettype wire

FILE: rtl/dsw_checker.sv
// Port-level checks of the stopwatch top level, attached by bind.
// Depends on the top level's interface ports only.
`default_nettype none

module dsw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] segments,
  input wire logic [3:0] digit_enable,
  input wire logic [3:0] sec_ones,
  input wire logic [2:0] sec_tens,
  input wire logic [3:0] min_ones,
  input wire logic [2:0] min_tens
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(digit_enable))
    else $error("digit enable not one-hot");

  // Every valid digit has a lit pattern, so blank segments mean no digit yet
  a_blank_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((segments == 7'd0) == (digit_enable == 4'd0)))
    else $error("segment latch and enable latch disagree");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sec_ones <= 4'd9 && sec_tens <= 3'd5 &&
                   min_ones <= 4'd9 && min_tens <= 3'd5))
    else $error("time digit out of range");

endmodule

bind debounced_stopwatch_mmss_display_unit dsw_checker u_dsw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .segments     (out_bus.segments),
  .digit_enable (out_bus.digit_enable),
  .sec_ones     (out_bus.sec_ones),
  .sec_tens     (out_bus.sec_tens),
  .min_ones     (out_bus.min_ones),
  .min_tens     (out_bus.min_tens)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for the debounced MM:SS stopwatch display unit.
// Depends on dsw_pkg, the dsw_*_if interfaces and the top-level RTL.
// A scoreboard class predicts each result beat; plain tasks drive the polls.

module tb_top
  import dsw_pkg::*;
;

  // Index that selects no register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;

  // ---------------------------------------------------------------------------
  // Scoreboard: own copy of the stopwatch state, one expected beat per poll.
  // ---------------------------------------------------------------------------
  class stopwatch_tracker;
    bit [7:0]    debounce_lim;
    bit [15:0]   second_lim;
    bit [1:0]    scan;
    bit [1:0]    last_scan;
    bit [7:0]    stable_count;
    bit          prev_level;
    bit          held_level;
    bit          run;
    bit [15:0]   subsec;
    bit [3:0]    digit [4];
    bit [6:0]    seg_hold;
    bit [3:0]    enable_hold;
    dsw_result_t expected_q [$];
    int          errors;
    int          reports;

    function new();
      debounce_lim = DEBOUNCE_LIMIT_RST;
      second_lim   = SECOND_LIMIT_RST;
      scan         = '0;
      last_scan    = '0;
      stable_count = '0;
      prev_level   = 1'b0;
      held_level   = 1'b1;
      run          = 1'b0;
      subsec       = '0;
      foreach (digit[i]) digit[i] = '0;
      seg_hold     = '0;
      enable_hold  = '0;
      errors       = 0;
      reports      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DEBOUNCE_LIMIT) begin
        debounce_lim = data[7:0];
      end else if (idx == REG_SECOND_LIMIT) begin
        second_lim = data;
      end
    endfunction

    // segments a..g on bits 0..6; anything above nine is dark
    function bit [6:0] digit_pattern(bit [3:0] d);
      case (d)
        4'd0:    return 7'h3F;
        4'd1:    return 7'h06;
        4'd2:    return 7'h5B;
        4'd3:    return 7'h4F;
        4'd4:    return 7'h66;
        4'd5:    return 7'h6D;
        4'd6:    return 7'h7D;
        4'd7:    return 7'h07;
        4'd8:    return 7'h7F;
        4'd9:    return 7'h6F;
        default: return 7'h00;
      endcase
    endfunction

    // ripple carry through SS then MM, 59:59 rolls to 00:00
    function void bump_seconds();
      bit [3:0] top;
      for (int i = 0; i < 4; i++) begin
        top = (i % 2 == 0) ? 4'd9 : 4'd5;
        if (digit[i] == top) begin
          digit[i] = '0;
        end else begin
          digit[i] = digit[i] + 4'd1;
          return;
        end
      end
    endfunction

    function void note_poll(bit tick, bit level);
      dsw_result_t r;
      if (tick) begin
        scan = scan + 2'd1;
        if (stable_count != 0) stable_count = stable_count + 8'd1;
        if (run) subsec = subsec + 16'd1;
      end
      if (level != prev_level) begin
        stable_count = 8'd1;
      end else if (stable_count > debounce_lim) begin
        held_level   = level;
        stable_count = '0;
      end
      prev_level = level;
      if (held_level == 1'b0) begin
        run        = ~run;
        held_level = 1'b1;
      end
      if (subsec > second_lim) begin
        subsec = '0;
        bump_seconds();
      end
      if (scan != last_scan) begin
        seg_hold    = digit_pattern(digit[scan]);
        enable_hold = 4'b0001 << scan;
        last_scan   = scan;
      end
      r.segments        = seg_hold;
      r.digit_enable    = enable_hold;
      r.running         = run;
      r.digits.sec_ones = digit[0];
      r.digits.sec_tens = digit[1][2:0];
      r.digits.min_ones = digit[2];
      r.digits.min_tens = digit[3][2:0];
      expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void match_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        reports++;
        if (reports <= 200) $error("%s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(dsw_result_t got);
      dsw_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        reports++;
        if (reports <= 200) $error("result beat arrived with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      match_field("segments",     want.segments,        got.segments);
      match_field("digit_enable", want.digit_enable,    got.digit_enable);
      match_field("running",      want.running,         got.running);
      match_field("sec_ones",     want.digits.sec_ones, got.digits.sec_ones);
      match_field("sec_tens",     want.digits.sec_tens, got.digits.sec_tens);
      match_field("min_ones",     want.digits.min_ones, got.digits.min_ones);
      match_field("min_tens",     want.digits.min_tens, got.digits.min_tens);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  dsw_in_if  in_ch ();
  dsw_out_if out_ch ();
  dsw_cfg_if cfg_ch ();

  debounced_stopwatch_mmss_display_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  stopwatch_tracker tracker;

  // calm: no random idling on either side (long stretches, hold-off test)
  bit calm;
  // receiver hold-off: stimulus posts a length, the receiver counts it down
  int hold_req;
  int hold_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge, beats are taken on the rising.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(99) < 30) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    dsw_result_t seen;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.segments        = out_ch.segments;
      seen.digit_enable    = out_ch.digit_enable;
      seen.running         = out_ch.running;
      seen.digits.sec_ones = out_ch.sec_ones;
      seen.digits.sec_tens = out_ch.sec_tens;
      seen.digits.min_ones = out_ch.min_ones;
      seen.digits.min_tens = out_ch.min_tens;
      tracker.check_result(seen);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. Each starts and ends at a falling edge, so every input gets
  // at most one update per time step.
  // ---------------------------------------------------------------------------

  // One poll beat; random idle cycles ahead of it carry junk payload.
  task automatic send_poll(input bit tick, input bit level);
    while (!calm && $urandom_range(99) < 30) begin
      in_ch.valid        <= 1'b0;
      in_ch.timer_tick   <= 1'($urandom_range(1));
      in_ch.button_level <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.timer_tick   <= tick;
    in_ch.button_level <= level;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    tracker.note_poll(tick, level);
    @(negedge clk);
  endtask

  // Stop sending and let every expected beat come back, plus a small margin.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Leaves cfg valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    tracker.write_register(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] db_data, input logic [15:0] sl_data,
                           input bit poke_unused);
    wait_drained();
    write_reg(REG_DEBOUNCE_LIMIT, db_data);
    write_reg(REG_SECOND_LIMIT, sl_data);
    if (poke_unused) write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold a level for enough ticks to be accepted at the current limit.
  task automatic hold_level(input bit level);
    int n;
    n = int'(tracker.debounce_lim) + 2;
    repeat (n) send_poll(1'b1, level);
  endtask

  // Release then press until the predicted state says the count is running.
  task automatic start_counting();
    while (!tracker.run) begin
      hold_level(1'b1);
      hold_level(1'b0);
    end
  endtask

  // Button activity with random ticks: mostly clean holds around the accept
  // boundary, some short bounces, some single-poll noise.
  task automatic random_burst(input int count);
    int  sent;
    int  lim;
    int  mode;
    int  ticks_needed;
    int  got_ticks;
    bit  tk;
    bit  level;
    sent = 0;
    while (sent < count) begin
      lim  = tracker.debounce_lim;
      mode = $urandom_range(9);
      if (mode >= 9) begin
        send_poll(1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
        continue;
      end
      if (mode < 2) begin
        ticks_needed = $urandom_range(0, 2);          // contact bounce
      end else if (mode == 7) begin
        ticks_needed = (lim > 0) ? lim - 1 : 0;       // one tick short
      end else begin
        ticks_needed = lim + $urandom_range(0, 3);    // at or past the limit
      end
      level = ~tracker.prev_level;
      send_poll($urandom_range(99) < 75, level);
      sent++;
      got_ticks = 0;
      while (got_ticks < ticks_needed) begin
        tk = ($urandom_range(99) < 75);
        send_poll(tk, level);
        if (tk) got_ticks++;
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          phase;
    logic [7:0]  dl;
    logic [15:0] sl;
    logic [7:0]  junk;

    tracker            = new();
    clk                = 1'b0;
    rst_n              = 1'b0;
    calm               = 1'b0;
    hold_req           = 0;
    hold_left          = 0;
    in_ch.valid        = 1'b0;
    in_ch.timer_tick   = 1'b0;
    in_ch.button_level = 1'b0;
    out_ch.ready       = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed: reset limits first, then limit 0 / 1 for fast toggling
    send_poll(1'b0, 1'b0);
    send_poll(1'b1, 1'b1);
    wait_drained();
    write_reg(REG_DEBOUNCE_LIMIT, 16'hFF00);   // upper byte must be dropped
    write_reg(REG_SECOND_LIMIT, 16'd1);
    write_reg(REG_NONE, 16'hFFFF);             // no such register
    cfg_ch.valid <= 1'b0;
    send_poll(1'b1, 1'b1);                     // release accepted
    send_poll(1'b0, 1'b0);
    send_poll(1'b1, 1'b0);                     // press accepted: run
    repeat (5) send_poll(1'b1, 1'b0);          // seconds roll
    send_poll(1'b0, 1'b0);
    send_poll(1'b1, 1'b1);
    send_poll(1'b1, 1'b1);
    send_poll(1'b1, 1'b0);
    send_poll(1'b1, 1'b0);                     // second press: pause
    send_poll(1'b1, 1'b0);                     // tick while paused
    send_poll(1'b0, 1'b1);

    // --- a minute at two ticks a second: seconds carry into the minutes
    configure(16'h0000, 16'd1, 1'b0);
    start_counting();
    calm = 1'b1;
    repeat (124) send_poll(1'b1, 1'b0);
    calm = 1'b0;

    // --- top limits: debounce counter runs past 255 and idles, the
    //     time stays frozen at the top second limit
    configure(16'h0000, 16'd1, 1'b0);
    start_counting();
    configure(16'h5AFF, 16'hFFFF, 1'b0);
    calm = 1'b1;
    send_poll(1'b1, 1'b1);
    repeat (260) send_poll(1'b1, 1'b1);
    calm = 1'b0;

    // --- random phases over a spread of limits
    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin
          dl = 8'd0;
          sl = 16'd1;
        end
        1: begin
          dl = 8'd1;
          sl = 16'd2;
        end
        2: begin
          dl = 8'd254;
          sl = 16'd3;
        end
        3: begin
          dl = 8'd2;
          sl = 16'd65534;
        end
        default: begin
          dl = 8'($urandom_range(0, 12));
          sl = 16'($urandom_range(1, 6));
        end
      endcase
      junk = 8'($urandom);
      configure({junk, dl}, sl, phase % 3 == 0);
      if (phase == 5) begin
        // receiver holds off while polls keep coming: input must back up
        calm     = 1'b1;
        hold_req = 60;
        random_burst(40);
      end
      calm = (phase == 7);
      random_burst(phase == 2 ? 300 : 80);
      calm = 1'b0;
    end

    // --- drain and report
    wait_drained();
    repeat (8) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("PASS debounced_stopwatch_mmss_display_unit");
    end else begin
      $display("FAIL debounced_stopwatch_mmss_display_unit");
    end
    $finish;
  end

  // Hang guard, well above the slowest legal run
  initial begin
    #(12 * 1500000);
    $display("FAIL debounced_stopwatch_mmss_display_unit");
    $finish;
  end

endmodule
